FILE: hdl/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

  localparam int unsigned HdrLenBytes = 4;
  localparam int unsigned HdrCntW     = $clog2(HdrLenBytes + 1);
  localparam logic [31:0] MaxLenReset = 32'd16777216;

  // Register index as decoded from paddr
  localparam logic REG_MAX_LEN    = 1'b0;
  localparam logic REG_BIG_ENDIAN = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  opcode;
    logic [31:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] max_len;
    logic        big_endian;
  } cfg_t;

endpackage

FILE: hdl/lpd_front.sv
// Front end: accepts stream words, tracks the frame header and classifies each word.
module lpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lpd_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output lpd_pkg::result_t push_data_o
);
  import lpd_pkg::*;

  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [31:0]        len_q, len_d;
  logic [7:0]         opcode_q, opcode_d;
  logic [31:0]        remain_q, remain_d;
  logic               failed_q, failed_d;
  logic               accept;
  logic [31:0]        len_base;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign len_base   = (hdr_cnt_q == '0) ? 32'd0 : len_q;

  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    len_d       = len_q;
    opcode_d    = opcode_q;
    remain_d    = remain_q;
    failed_d    = failed_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_PAYLOAD, data: rx_byte_i, opcode: opcode_q,
                    length: len_q, last: 1'b0};
    if (accept && !failed_q) begin
      if (remain_q != '0) begin
        remain_d         = remain_q - 32'd1;
        push_o           = 1'b1;
        push_data_o.last = (remain_q == 32'd1);
      end else if (hdr_cnt_q < HdrCntW'(HdrLenBytes)) begin
        hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
        if (cfg_i.big_endian) begin
          len_d = {len_base[23:0], rx_byte_i};
        end else begin
          len_d = len_base;
          case (hdr_cnt_q[1:0])
            2'd0:    len_d[7:0]   = len_base[7:0]   | rx_byte_i;
            2'd1:    len_d[15:8]  = len_base[15:8]  | rx_byte_i;
            2'd2:    len_d[23:16] = len_base[23:16] | rx_byte_i;
            default: len_d[31:24] = len_base[31:24] | rx_byte_i;
          endcase
        end
      end else begin
        // Opcode word closes the header
        opcode_d           = rx_byte_i;
        hdr_cnt_d          = '0;
        push_data_o.opcode = rx_byte_i;
        push_data_o.data   = 8'd0;
        if (len_q > cfg_i.max_len) begin
          failed_d         = 1'b1;
          push_o           = 1'b1;
          push_data_o.kind = KIND_ERROR;
        end else if (len_q == '0) begin
          push_o           = 1'b1;
          push_data_o.kind = KIND_EMPTY;
          push_data_o.last = 1'b1;
        end else begin
          remain_d = len_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      len_q     <= '0;
      opcode_q  <= '0;
      remain_q  <= '0;
      failed_q  <= 1'b0;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      opcode_q  <= opcode_d;
      remain_q  <= remain_d;
      failed_q  <= failed_d;
    end
  end

endmodule

FILE: hdl/lpd_queue.sv
// Two-entry result queue between front end and output stage.
module lpd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpd_pkg::result_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output lpd_pkg::result_t pop_data_o
);
  import lpd_pkg::*;

  result_t     mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hdl/lpd_back.sv
// Back end: output register that presents one result word at a time.
module lpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  lpd_pkg::result_t q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lpd_pkg::result_t out_data_o
);
  import lpd_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Load when the register is empty or its word leaves this cycle
  assign pop_o       = q_valid_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule

FILE: hdl/length_prefixed_deframer.sv
// Length-prefixed deframer top level: config registers, front end, queue, output stage.
// Each result is written into the queue, then into the output register, before it is valid at the outputs.
// Throughput: one input word per cycle, unless in_stall_o is raised while the queue is full.
// A two-entry queue holds up to two results while the output stalls, so the input keeps flowing until it is full.
// Reset (rst_ni low, asynchronous) clears the parser, the failed flag and the queue,
// and loads max_frame_length = 16777216 and length_big_endian = 1.
module length_prefixed_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  frame_opcode_o,
  output logic [31:0] frame_length_o,
  output logic        last_of_frame_o
);
  import lpd_pkg::*;

  cfg_t    cfg_q;
  logic    cfg_wr;
  logic    push, q_full, pop, q_valid;
  result_t push_data, q_data, out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_len    <= MaxLenReset;
      cfg_q.big_endian <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_LEN:    cfg_q.max_len    <= pwdata;
        REG_BIG_ENDIAN: cfg_q.big_endian <= pwdata[0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_LEN:    prdata = cfg_q.max_len;
      REG_BIG_ENDIAN: prdata = {31'd0, cfg_q.big_endian};
      default:        prdata = 32'd0;
    endcase
  end

  lpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  lpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign result_kind_o   = out_data.kind;
  assign payload_byte_o  = out_data.data;
  assign frame_opcode_o  = out_data.opcode;
  assign frame_length_o  = out_data.length;
  assign last_of_frame_o = out_data.last;

endmodule
